// ===== rtl/scq_pkg.sv =====
// Shared types, command codes and frame constants for the sound cue queue sequencer.
// No dependencies; the queue, serializer and top rtl files refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package scq_pkg;

    // Input command codes
    localparam logic [3:0] CMD_TICK         = 4'd0;
    localparam logic [3:0] CMD_ENQ_TRACK    = 4'd1;
    localparam logic [3:0] CMD_ENQ_SILENCE  = 4'd2;
    localparam logic [3:0] CMD_CLEAR        = 4'd3;
    localparam logic [3:0] CMD_WRITE_DUR    = 4'd4;
    localparam logic [3:0] CMD_READ_DUR     = 4'd5;
    localparam logic [3:0] CMD_VOLUME       = 4'd6;
    localparam logic [3:0] CMD_PLAY_INDEX   = 4'd7;
    localparam logic [3:0] CMD_FOLDER_TRACK = 4'd8;
    localparam logic [3:0] CMD_RAW_BYTE     = 4'd9;

    // Player frame opcodes
    localparam logic [7:0] OP_PLAY_INDEX   = 8'h03;
    localparam logic [7:0] OP_VOLUME       = 8'h06;
    localparam logic [7:0] OP_FOLDER_TRACK = 8'h0F;

    // Fixed frame bytes
    localparam logic [7:0] FRAME_START   = 8'h7E;
    localparam logic [7:0] FRAME_VERSION = 8'hFF;
    localparam logic [7:0] FRAME_LENGTH  = 8'h06;
    localparam logic [7:0] FRAME_NOACK   = 8'h00;
    localparam logic [7:0] FRAME_END     = 8'hEF;

    localparam logic [7:0]  FOLDER_MIN  = 8'd1;
    localparam logic [7:0]  FOLDER_MAX  = 8'd99;
    localparam logic [15:0] VOLUME_MAX  = 16'd30;
    localparam logic [19:0] DUR_BASE_MS = 20'd50;

    // What a result run carries
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_RAW   = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    localparam int CUE_W = 17;   // bit 16 set = silence cue

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [CUE_W-1:0] wdata;
    } q_ctrl_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  op;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] table_data;
        logic        dropped;
        logic        playing;
    } tx_req_t;

    function automatic logic [7:0] clamp_folder(input logic [7:0] f);
        logic [7:0] r;
        r = f;
        if (f > FOLDER_MAX) r = FOLDER_MAX;
        if (f < FOLDER_MIN) r = FOLDER_MIN;
        return r;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [7:0] op,
                                              input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] b;
        case (idx)
            3'd0:    b = FRAME_START;
            3'd1:    b = FRAME_VERSION;
            3'd2:    b = FRAME_LENGTH;
            3'd3:    b = op;
            3'd4:    b = FRAME_NOACK;
            3'd5:    b = hi;
            3'd6:    b = lo;
            default: b = FRAME_END;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scq_cue_queue.sv =====
// Cue queue: circular buffer in a synchronous memory with head pointer and fill count.
// Depends on scq_pkg (q_ctrl_t, CUE_W).
`timescale 1ns / 1ps
`default_nettype none

module scq_cue_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire scq_pkg::q_ctrl_t    ctrl,
    output logic [scq_pkg::CUE_W-1:0] rd_data,
    output logic                     empty,
    output logic                     full
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [scq_pkg::CUE_W-1:0] q_mem [QUEUE_DEPTH];
    logic [scq_pkg::CUE_W-1:0] rd_data_reg;
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW:0]               tail_sum;
    logic [AW-1:0]             tail;

    assign tail_sum = {1'b0, head_reg} + (AW + 1)'(count_reg);
    assign tail     = (tail_sum >= (AW + 1)'(QUEUE_DEPTH))
                    ? AW'(tail_sum - (AW + 1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign rd_data = rd_data_reg;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.pop && !empty) begin
            head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (ctrl.push && !full) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Head entry is read every cycle into a registered output.
    always_ff @(posedge aclk) begin
        if (ctrl.push && !full && !ctrl.clear) begin
            q_mem[tail] <= ctrl.wdata;
        end
        rd_data_reg <= q_mem[head_reg];
    end

endmodule

`default_nettype wire

// ===== rtl/scq_dur_mem.sv =====
// Duration table: single write port, single registered read port.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps
`default_nettype none

module scq_dur_mem #(
    parameter int TABLE_DEPTH = 32768
) (
    input  wire                            aclk,
    input  wire                            we,
    input  wire [$clog2(TABLE_DEPTH)-1:0]  waddr,
    input  wire [15:0]                     wdata,
    input  wire [$clog2(TABLE_DEPTH)-1:0]  raddr,
    output logic [15:0]                    rd_data
);

    logic [15:0] dur_mem [TABLE_DEPTH];
    logic [15:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            dur_mem[waddr] <= wdata;
        end
        rd_data_reg <= dur_mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/scq_tx_stage.sv =====
// Serializer: frames give frame bytes, other kinds one byte; holds the m_ output register.
// Depends on scq_pkg (tx_req_t, frame_byte, KIND_*).
`timescale 1ns / 1ps
`default_nettype none

module scq_tx_stage (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  wire scq_pkg::tx_req_t  req,
    output logic                   busy,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [31:0]            m_tdata,
    output logic [0:0]             m_tuser,
    output logic                   m_tlast
);

    scq_pkg::tx_req_t req_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;
    logic             m_tuser_reg;
    logic             m_tlast_reg;
    logic             load;
    logic             last_one;
    logic [7:0]       tx_byte;

    assign load     = busy_reg && (!m_tvalid_reg || m_tready);
    assign last_one = (req_reg.kind != scq_pkg::KIND_FRAME) || (cnt_reg == 3'd7);

    always_comb begin
        case (req_reg.kind)
            scq_pkg::KIND_FRAME:
                tx_byte = scq_pkg::frame_byte(cnt_reg, req_reg.op, req_reg.hi, req_reg.lo);
            scq_pkg::KIND_RAW: tx_byte = req_reg.lo;
            default:           tx_byte = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (load) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_one) begin
                    busy_reg <= 1'b0;
                end
            end
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            req_reg <= req;
        end
        if (load) begin
            m_tdata_reg <= {6'd0, req_reg.dropped, req_reg.table_data, req_reg.playing, tx_byte};
            m_tuser_reg <= (req_reg.kind != scq_pkg::KIND_NONE);
            m_tlast_reg <= last_one;
        end
    end

    assign busy       = busy_reg;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/sound_cue_queue_sequencer_top.sv =====
// The first result passes ST_EXEC, then ST_DUR when a duration lookup is needed, then ST_SEND
// and the serializer output register. One transaction at a time: the input stays closed until
// the serializer has loaded the item's last result. The output register moves one frame byte
// per cycle while the sink is ready.
// Reset: aresetn synchronous, active low; clears queue pointers, countdown and handshake state.
// Queue and duration memory contents are undefined until written; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sound_cue_queue_sequencer_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TABLE_DEPTH = 32768
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Command channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // folder[7:0], track[15:8], value[31:16], table_index[46:32]
    input  wire  [3:0]  s_tuser,   // command[3:0]
    // Result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], playing[8], table_data[24:9], dropped[25]
    output logic [0:0]  m_tuser,   // tx_valid[0]
    output logic        m_tlast
);

    localparam int DAW = $clog2(TABLE_DEPTH);
    localparam logic [15:0] TD = 16'(TABLE_DEPTH);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;   // apply the command: queue update, duration write
    localparam logic [1:0] ST_DUR  = 2'd2;   // duration read data back
    localparam logic [1:0] ST_SEND = 2'd3;   // hand result to serializer

    logic [1:0]  state_reg, state_next;

    // Captured transaction
    logic [3:0]  cmd_reg;
    logic [7:0]  folder_reg;
    logic [7:0]  track_reg;
    logic [15:0] value_reg;
    logic [14:0] tidx_reg;

    // Countdown in ms; max 65535*10+50 fits 20 bits
    logic [19:0] rem_reg, rem_next;
    logic [19:0] rem_dec;

    scq_pkg::tx_req_t req_reg, req_next, tx_req;
    logic             dur_ok_reg, dur_ok_next;

    // Queue interface
    scq_pkg::q_ctrl_t          q_ctrl;
    logic [scq_pkg::CUE_W-1:0] q_rd;
    logic                      q_empty;
    logic                      q_full;

    // Duration memory interface
    logic            dur_we;
    logic [DAW-1:0]  dur_raddr;
    logic [15:0]     dur_rd;
    logic [19:0]     dur_scaled;

    logic            tx_start;
    logic            tx_busy;

    // Popped track cue lookup
    logic [7:0]  pop_folder;
    logic [7:0]  pop_folder_m1;
    logic [14:0] pop_idx;
    logic        pop_idx_ok;
    logic        tidx_ok;
    logic        pop_go;

    assign rem_dec       = (rem_reg != '0) ? rem_reg - 1'b1 : '0;
    assign pop_go        = (rem_dec == '0) && !q_empty;
    assign pop_folder    = scq_pkg::clamp_folder(q_rd[15:8]);
    assign pop_folder_m1 = pop_folder - 8'd1;
    assign pop_idx       = {pop_folder_m1[6:0], q_rd[7:0]};
    assign pop_idx_ok    = ({1'b0, pop_idx} < TD);
    assign tidx_ok       = ({1'b0, tidx_reg} < TD);
    assign dur_raddr     = (cmd_reg == scq_pkg::CMD_TICK) ? pop_idx[DAW-1:0] : tidx_reg[DAW-1:0];
    // d*10 + 50 as shifts and adds
    assign dur_scaled    = ({4'd0, dur_rd} << 3) + ({4'd0, dur_rd} << 1) + scq_pkg::DUR_BASE_MS;

    // One item in flight: every memory write retires in ST_EXEC, and ST_SEND lies between it
    // and the next accept, so the head read registered at accept is always current.
    assign s_tready = (state_reg == ST_IDLE) && !tx_busy;

    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        req_next    = req_reg;
        dur_ok_next = dur_ok_reg;
        q_ctrl      = '0;
        dur_we      = 1'b0;
        tx_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                req_next   = '0;
                state_next = ST_SEND;
                case (cmd_reg)
                    scq_pkg::CMD_TICK: begin
                        rem_next = rem_dec;
                        if (pop_go) begin
                            q_ctrl.pop = 1'b1;
                            if (q_rd[16]) begin
                                rem_next = {4'd0, q_rd[15:0]};
                            end else begin
                                req_next.kind = scq_pkg::KIND_FRAME;
                                req_next.op   = scq_pkg::OP_FOLDER_TRACK;
                                req_next.hi   = pop_folder;
                                req_next.lo   = q_rd[7:0];
                                dur_ok_next   = pop_idx_ok;
                                state_next    = ST_DUR;
                            end
                        end
                    end
                    scq_pkg::CMD_ENQ_TRACK: begin
                        q_ctrl.push      = 1'b1;
                        q_ctrl.wdata     = {1'b0, folder_reg, track_reg};
                        req_next.dropped = q_full;
                    end
                    scq_pkg::CMD_ENQ_SILENCE: begin
                        q_ctrl.push      = 1'b1;
                        q_ctrl.wdata     = {1'b1, value_reg};
                        req_next.dropped = q_full;
                    end
                    scq_pkg::CMD_CLEAR: begin
                        q_ctrl.clear = 1'b1;
                    end
                    scq_pkg::CMD_WRITE_DUR: begin
                        dur_we = tidx_ok;
                    end
                    scq_pkg::CMD_READ_DUR: begin
                        dur_ok_next = tidx_ok;
                        state_next  = ST_DUR;
                    end
                    scq_pkg::CMD_VOLUME: begin
                        req_next.kind = scq_pkg::KIND_FRAME;
                        req_next.op   = scq_pkg::OP_VOLUME;
                        req_next.hi   = 8'd0;
                        req_next.lo   = (value_reg > scq_pkg::VOLUME_MAX)
                                      ? scq_pkg::VOLUME_MAX[7:0] : value_reg[7:0];
                    end
                    scq_pkg::CMD_PLAY_INDEX: begin
                        req_next.kind = scq_pkg::KIND_FRAME;
                        req_next.op   = scq_pkg::OP_PLAY_INDEX;
                        req_next.hi   = value_reg[15:8];
                        req_next.lo   = value_reg[7:0];
                    end
                    scq_pkg::CMD_FOLDER_TRACK: begin
                        req_next.kind = scq_pkg::KIND_FRAME;
                        req_next.op   = scq_pkg::OP_FOLDER_TRACK;
                        req_next.hi   = scq_pkg::clamp_folder(folder_reg);
                        req_next.lo   = track_reg;
                    end
                    scq_pkg::CMD_RAW_BYTE: begin
                        req_next.kind = scq_pkg::KIND_RAW;
                        req_next.lo   = value_reg[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            ST_DUR: begin
                // Out-of-table lookups read as zero
                if (cmd_reg == scq_pkg::CMD_TICK) begin
                    rem_next = dur_ok_reg ? dur_scaled : scq_pkg::DUR_BASE_MS;
                end else begin
                    req_next.table_data = dur_ok_reg ? dur_rd : 16'd0;
                end
                state_next = ST_SEND;
            end
            ST_SEND: begin
                tx_start   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Playing status after this item's updates: countdown and count are settled by ST_SEND
    always_comb begin
        tx_req         = req_reg;
        tx_req.playing = (rem_reg != '0) || !q_empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg    <= s_tuser;
            folder_reg <= s_tdata[7:0];
            track_reg  <= s_tdata[15:8];
            value_reg  <= s_tdata[31:16];
            tidx_reg   <= s_tdata[46:32];
        end
        req_reg    <= req_next;
        dur_ok_reg <= dur_ok_next;
    end

    scq_cue_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_cue_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .rd_data (q_rd),
        .empty   (q_empty),
        .full    (q_full)
    );

    scq_dur_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dur_mem (
        .aclk    (aclk),
        .we      (dur_we),
        .waddr   (tidx_reg[DAW-1:0]),
        .wdata   (value_reg),
        .raddr   (dur_raddr),
        .rd_data (dur_rd)
    );

    scq_tx_stage u_tx_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tx_start),
        .req      (tx_req),
        .busy     (tx_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/scq_checker.sv =====
// Port-level checker for the sequencer top, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module scq_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [0:0]  m_tuser,
    input wire        m_tlast
);

    // An accepted command closes the input, so no two commands are accepted back to back
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // A result waiting on a stalled sink stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // Results with tx_valid low are single transactions with a zero byte
    a_noframe_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("non-frame result not single or byte nonzero");

    // Nonzero table data only travels with a result whose tx_valid is low
    a_table_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[24:9] != 16'd0) |-> !m_tuser[0])
        else $error("table data on a frame byte");

    // A refused enqueue emits no frame
    a_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> !m_tuser[0] && m_tlast)
        else $error("dropped flag on a frame byte");

endmodule

bind sound_cue_queue_sequencer_top scq_checker u_scq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/tb_sound_cue_queue_sequencer_top.sv =====
// Self-checking testbench for sound_cue_queue_sequencer_top: a directed table, then random
// command streams checked against a cycle-free model of the cue queue and player frames.
// Depends on rtl/scq_pkg.sv and rtl/sound_cue_queue_sequencer_top.sv.
`timescale 1ns / 1ps

module tb_sound_cue_queue_sequencer_top;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TABLE_DEPTH  = 32768;
    // Folders 1..99 address entries below this index; those hold short durations only
    localparam int TRACK_REGION = 99 * 256;
    localparam int SHORT_DUR_MAX  = 2;
    localparam int SILENCE_MAX_MS = 3;
    localparam logic [19:0] DUR_SCALE = 20'd10;

    localparam logic [3:0] CMD_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

    localparam int TOTAL_ITEMS  = 482;
    localparam int STEADY_FROM  = 180;   // no idling on either side between these item counts
    localparam int STEADY_TO    = 280;
    localparam int PRESSURE_AT  = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int DIR_ROWS     = 22;
    localparam int DUE_DEPTH    = 64;    // results awaited never exceed two items' worth

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  folder;
        logic [7:0]  track;
        logic [15:0] value;
        logic [14:0] tindex;
    } cue_cmd_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        last;
        logic        playing;
        logic [15:0] table_data;
        logic        dropped;
    } player_out_t;

    // One directed row; where typed is set, the single result is given in the row itself
    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  folder;
        logic [7:0]  track;
        logic [15:0] value;
        logic [14:0] tindex;
        logic        typed;
        logic        playing;
        logic [15:0] data;
        logic        dropped;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // tick straight after reset: countdown stays at zero, nothing plays
        '{scq_pkg::CMD_TICK, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b0, 16'h0000, 1'b0},
        // unused commands change nothing, with all fields at their top and at zero
        '{CMD_UNUSED_LAST, 8'hFF, 8'hFF, 16'hFFFF, 15'h7FFF,
          1'b1, 1'b0, 16'h0000, 1'b0},
        '{CMD_UNUSED_FIRST, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b0, 16'h0000, 1'b0},
        // duration entries at both ends of the table
        '{scq_pkg::CMD_WRITE_DUR, 8'h00, 8'h00, 16'hFFFF, 15'h7FFF,
          1'b1, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_READ_DUR, 8'h00, 8'h00, 16'h0000, 15'h7FFF,
          1'b1, 1'b0, 16'hFFFF, 1'b0},
        '{scq_pkg::CMD_WRITE_DUR, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_READ_DUR, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b0, 16'h0000, 1'b0},
        // volume clamp well above, just above and below the limit
        '{scq_pkg::CMD_VOLUME, 8'h00, 8'h00, 16'hFFFF, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_VOLUME, 8'h00, 8'h00, 16'h001F, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_VOLUME, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_PLAY_INDEX, 8'h00, 8'h00, 16'hA55A, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        // folder clamp at both ends
        '{scq_pkg::CMD_FOLDER_TRACK, 8'h00, 8'hFF, 16'h0000, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_FOLDER_TRACK, 8'hFF, 8'h00, 16'h0000, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_RAW_BYTE, 8'h00, 8'h00, 16'h12AB, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        // longest silence is queued, then cleared away before it can play
        '{scq_pkg::CMD_ENQ_SILENCE, 8'h00, 8'h00, 16'hFFFF, 15'h0000,
          1'b1, 1'b1, 16'h0000, 1'b0},
        '{scq_pkg::CMD_CLEAR, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b0, 16'h0000, 1'b0},
        // last entry reachable by a clamped folder 99, track 255
        '{scq_pkg::CMD_WRITE_DUR, 8'h00, 8'h00, 16'h0000, 15'h62FF,
          1'b1, 1'b0, 16'h0000, 1'b0},
        '{scq_pkg::CMD_ENQ_TRACK, 8'hFF, 8'hFF, 16'h0000, 15'h0000,
          1'b1, 1'b1, 16'h0000, 1'b0},
        '{scq_pkg::CMD_ENQ_SILENCE, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b1, 16'h0000, 1'b0},
        // pops the track cue and loads a 50 ms countdown
        '{scq_pkg::CMD_TICK, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b0, 1'b0, 16'h0000, 1'b0},
        // clear keeps the running countdown, so the player still plays
        '{scq_pkg::CMD_CLEAR, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b1, 16'h0000, 1'b0},
        '{scq_pkg::CMD_TICK, 8'h00, 8'h00, 16'h0000, 15'h0000,
          1'b1, 1'b1, 16'h0000, 1'b0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // folder[7:0], track[15:8], value[31:16], table_index[46:32]
    logic [3:0]  s_tuser  = '0;   // command[3:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // tx_byte[7:0], playing[8], table_data[24:9], dropped[25]
    logic [0:0]  m_tuser;         // tx_valid[0]
    logic        m_tlast;

    // Receiver hold-off and the stretch without idling, both driven with NBAs
    logic hold_off = 1'b0;
    logic no_idle  = 1'b0;

    int items_sent   = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    // Model state: the cue ring, its pointers, the countdown and the written duration entries
    logic [16:0] cue_ring [QUEUE_DEPTH];
    int unsigned ring_head  = 0;
    int unsigned ring_count = 0;
    logic [19:0] countdown_ms = '0;
    logic [15:0] dur_mem [int];
    int          written_idx [TABLE_DEPTH];
    int          written_cnt = 0;

    // Results of the transaction just modeled
    player_out_t step_res [8];
    int          step_cnt = 0;

    // Results still awaited on the master side, as a ring with free-running counters
    player_out_t due_ring [DUE_DEPTH];
    int          due_wr = 0;
    int          due_rd = 0;

    sound_cue_queue_sequencer_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] fold_clamp(input logic [7:0] f);
        if (f > scq_pkg::FOLDER_MAX) return scq_pkg::FOLDER_MAX;
        if (f < scq_pkg::FOLDER_MIN) return scq_pkg::FOLDER_MIN;
        return f;
    endfunction

    function automatic logic [15:0] dur_lookup(input int idx);
        if (idx < TABLE_DEPTH && dur_mem.exists(idx)) return dur_mem[idx];
        return 16'h0000;
    endfunction

    // Applies one command to the model and leaves its results in step_res
    task automatic sequencer_step(input cue_cmd_t c);
        logic [7:0]  fb [8];
        logic [7:0]  op, hi, lo, f;
        logic [16:0] cue;
        logic [15:0] tdata;
        logic        drop, play, is_frame, is_raw;
        int          n, idx;
        player_out_t r;

        op = '0; hi = '0; lo = '0;
        tdata = '0; drop = 1'b0; is_frame = 1'b0; is_raw = 1'b0;
        step_cnt = 0;

        case (c.cmd)
            scq_pkg::CMD_TICK: begin
                if (countdown_ms != 0) countdown_ms = countdown_ms - 1;
                if (countdown_ms == 0 && ring_count != 0) begin
                    cue = cue_ring[ring_head];
                    ring_head = (ring_head + 1) % QUEUE_DEPTH;
                    ring_count--;
                    if (cue[16]) begin
                        countdown_ms = {4'd0, cue[15:0]};
                    end else begin
                        f = fold_clamp(cue[15:8]);
                        op = scq_pkg::OP_FOLDER_TRACK; hi = f; lo = cue[7:0];
                        is_frame = 1'b1;
                        idx = (int'(f) - 1) * 256 + int'(cue[7:0]);
                        countdown_ms = {4'd0, dur_lookup(idx)} * DUR_SCALE
                                     + scq_pkg::DUR_BASE_MS;
                    end
                end
            end
            scq_pkg::CMD_ENQ_TRACK, scq_pkg::CMD_ENQ_SILENCE: begin
                if (ring_count >= QUEUE_DEPTH) begin
                    drop = 1'b1;
                end else begin
                    cue_ring[(ring_head + ring_count) % QUEUE_DEPTH] =
                        (c.cmd == scq_pkg::CMD_ENQ_SILENCE) ? {1'b1, c.value}
                                                            : {1'b0, c.folder, c.track};
                    ring_count++;
                end
            end
            scq_pkg::CMD_CLEAR: ring_count = 0;
            scq_pkg::CMD_WRITE_DUR: begin
                if (!dur_mem.exists(int'(c.tindex))) begin
                    written_idx[written_cnt] = int'(c.tindex);
                    written_cnt++;
                end
                dur_mem[int'(c.tindex)] = c.value;
            end
            scq_pkg::CMD_READ_DUR: tdata = dur_lookup(int'(c.tindex));
            scq_pkg::CMD_VOLUME: begin
                op = scq_pkg::OP_VOLUME; is_frame = 1'b1;
                lo = (c.value > scq_pkg::VOLUME_MAX) ? scq_pkg::VOLUME_MAX[7:0] : c.value[7:0];
            end
            scq_pkg::CMD_PLAY_INDEX: begin
                op = scq_pkg::OP_PLAY_INDEX; hi = c.value[15:8]; lo = c.value[7:0];
                is_frame = 1'b1;
            end
            scq_pkg::CMD_FOLDER_TRACK: begin
                op = scq_pkg::OP_FOLDER_TRACK; hi = fold_clamp(c.folder); lo = c.track;
                is_frame = 1'b1;
            end
            scq_pkg::CMD_RAW_BYTE: is_raw = 1'b1;
            default: ;
        endcase

        fb = '{scq_pkg::FRAME_START, scq_pkg::FRAME_VERSION, scq_pkg::FRAME_LENGTH, op,
               scq_pkg::FRAME_NOACK, hi, lo, scq_pkg::FRAME_END};
        if (is_raw) fb[0] = c.value[7:0];
        play = !(countdown_ms == 0 && ring_count == 0);
        n = is_frame ? 8 : 1;
        for (int k = 0; k < n; k++) begin
            r.tx_byte    = (is_frame || is_raw) ? fb[k] : 8'h00;
            r.tx_valid   = is_frame || is_raw;
            r.last       = (k == n - 1);
            r.playing    = play;
            r.table_data = tdata;
            r.dropped    = drop;
            step_res[step_cnt] = r;
            step_cnt++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offers one transaction, waits for it to be taken, then records what it should cause
    task automatic send_cmd(input cue_cmd_t c, input logic use_typed, input player_out_t typed);
        while (!no_idle && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.tindex, c.value, c.track, c.folder};
        s_tuser  <= c.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sequencer_step(c);
        if (use_typed) begin
            due_ring[due_wr % DUE_DEPTH] = typed;
            due_wr++;
        end else begin
            for (int k = 0; k < step_cnt; k++) begin
                due_ring[due_wr % DUE_DEPTH] = step_res[k];
                due_wr++;
            end
        end
        items_sent++;
    endtask

    // Random fields for one command, kept inside the contract: track cues only ever play
    // entries that hold short durations, silences are short, reads hit written entries.
    task automatic issue_cmd(input logic [3:0] cmd);
        cue_cmd_t c, pre;
        int       idx;

        if (items_sent >= TOTAL_ITEMS) return;
        c.cmd    = cmd;
        c.folder = 8'($urandom);
        c.track  = 8'($urandom);
        c.value  = 16'($urandom);
        c.tindex = 15'($urandom);
        case (cmd)
            scq_pkg::CMD_ENQ_TRACK: begin
                idx = (int'(fold_clamp(c.folder)) - 1) * 256 + int'(c.track);
                if (!dur_mem.exists(idx)) begin
                    pre        = c;
                    pre.cmd    = scq_pkg::CMD_WRITE_DUR;
                    pre.value  = 16'($urandom_range(0, SHORT_DUR_MAX));
                    pre.tindex = 15'(idx);
                    send_cmd(pre, 1'b0, '0);
                end
            end
            scq_pkg::CMD_ENQ_SILENCE: c.value = 16'($urandom_range(0, SILENCE_MAX_MS));
            scq_pkg::CMD_WRITE_DUR:
                if (int'(c.tindex) < TRACK_REGION) c.value = 16'($urandom_range(0, SHORT_DUR_MAX));
            scq_pkg::CMD_READ_DUR:
                c.tindex = 15'(written_idx[$urandom_range(0, written_cnt - 1)]);
            scq_pkg::CMD_VOLUME: if ($urandom_range(0, 1)) c.value = 16'($urandom_range(0, 40));
            default: ;
        endcase
        send_cmd(c, 1'b0, '0);
    endtask

    // Master side: takes results, compares them in order, and decides tready for the next cycle
    always @(posedge aclk) begin
        player_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.tx_byte    = m_tdata[7:0];
            got.playing    = m_tdata[8];
            got.table_data = m_tdata[24:9];
            got.dropped    = m_tdata[25];
            got.tx_valid   = m_tuser[0];
            got.last       = m_tlast;
            if (due_wr == due_rd) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
                if (got.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
                if (got.playing !== want.playing)
                    report_mismatch("playing", 32'(got.playing), 32'(want.playing));
                if (got.table_data !== want.table_data)
                    report_mismatch("table_data", 32'(got.table_data), 32'(want.table_data));
                if (got.dropped !== want.dropped)
                    report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
            end
        end
        m_tready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 15);
    end

    // Long receiver hold-off while the sender keeps offering, so the block backs up
    initial begin
        wait (items_sent >= PRESSURE_AT);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Watchdog on cycles without any transaction on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        dir_row_t    row;
        cue_cmd_t    c;
        player_out_t typed;
        int          pick, runs;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row   = DIR_TABLE[r];
            c     = '{row.cmd, row.folder, row.track, row.value, row.tindex};
            typed = '{8'h00, 1'b0, 1'b1, row.playing, row.data, row.dropped};
            send_cmd(c, row.typed, typed);
        end

        // Mostly well-formed traffic: bursts of cues and runs of ticks, with direct
        // commands, table access, clears and some noise mixed in.
        while (items_sent < TOTAL_ITEMS) begin
            no_idle <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                runs = $urandom_range(1, 60);
                repeat (runs) issue_cmd(scq_pkg::CMD_TICK);
            end else if (pick < 58) begin
                runs = $urandom_range(1, 20);
                repeat (runs)
                    issue_cmd(($urandom_range(0, 9) < 6) ? scq_pkg::CMD_ENQ_SILENCE
                                                         : scq_pkg::CMD_ENQ_TRACK);
            end else if (pick < 70) begin
                runs = $urandom_range(1, 3);
                repeat (runs)
                    issue_cmd(4'($urandom_range(scq_pkg::CMD_VOLUME, scq_pkg::CMD_RAW_BYTE)));
            end else if (pick < 80) begin
                runs = $urandom_range(1, 4);
                repeat (runs)
                    issue_cmd($urandom_range(0, 1) ? scq_pkg::CMD_WRITE_DUR
                                                   : scq_pkg::CMD_READ_DUR);
            end else if (pick < 86) begin
                issue_cmd(scq_pkg::CMD_CLEAR);
            end else if (pick < 90) begin
                issue_cmd(4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)));
            end else begin
                issue_cmd(4'($urandom));
            end
        end
        s_tvalid <= 1'b0;
        no_idle  <= 1'b0;

        while (due_wr != due_rd) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sound_cue_queue_sequencer_top.f =====
rtl/scq_pkg.sv
rtl/scq_cue_queue.sv
rtl/scq_dur_mem.sv
rtl/scq_tx_stage.sv
rtl/sound_cue_queue_sequencer_top.sv
rtl/scq_checker.sv
sim/tb_sound_cue_queue_sequencer_top.sv
